// ----- src/srr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sprite row renderer.
// No dependencies; every other file of the block but srr_ram imports this package.
package srr_pkg;

  localparam int SPRITE_SIZE  = 16;
  localparam int PIXEL_W      = 3;
  localparam int ROW_W        = SPRITE_SIZE * PIXEL_W;
  localparam int ADDR_FIELD_W = 14;
  localparam int QUEUE_DEPTH  = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 9;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FLIP_X        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FLIP_Y        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [13:0]       load_address;
    logic [ROW_W-1:0]  load_pixels;
    logic [7:0]        pos_y_byte;
    logic [7:0]        attr_a;
    logic [7:0]        attr_b;
    logic [7:0]        pos_x_byte;
    logic [3:0]        row;
  } srr_in_t;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [5:0] pixel_value;
    logic       last;
  } srr_out_t;

  typedef struct packed {
    logic       flip_x;
    logic       flip_y;
    logic [8:0] screen_width;
    logic [8:0] screen_height;
  } srr_cfg_t;

  // Command passed from the front end to the back end through the queue
  typedef struct packed {
    logic                    is_load;
    logic [ADDR_FIELD_W-1:0] addr;    // tile store row, already wrapped
    logic [ROW_W-1:0]        pixels;  // load data
    logic [7:0]              x;       // screen column of sprite column 0
    logic [7:0]              y;       // screen line
    logic [SPRITE_SIZE-1:0]  mask;    // columns inside the clip window
    logic [2:0]              colour;
    logic                    fx;      // effective horizontal flip
  } srr_cmd_t;

endpackage

// ----- src/srr_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/srr_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input items, decodes sprite entries, clips and builds commands.
// Depends on srr_pkg.
module srr_front
  import srr_pkg::*;
#(
  parameter int TILE_COUNT = 1024
) (
  input  srr_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  srr_in_t  in_item,
  input  logic     q_full,
  output logic     push,
  output srr_cmd_t cmd
);

  localparam int CODE_MAX = 1023;
  localparam int TW       = $clog2(TILE_COUNT);
  localparam int Q_BITS   = $clog2(CODE_MAX / TILE_COUNT + 1);

  // Restoring reduction of a 10-bit code modulo the tile count
  function automatic logic [TW-1:0] tile_wrap(input logic [9:0] code);
    logic [10:0] r;
    r = {1'b0, code};
    for (int i = Q_BITS - 1; i >= 0; i--) begin
      if (r >= 11'(TILE_COUNT << i)) begin
        r = r - 11'(TILE_COUNT << i);
      end
    end
    return r[TW-1:0];
  endfunction

  logic [9:0]        code;
  logic [9:0]        code_sel;
  logic [TW-1:0]     tile;
  logic              fx;
  logic              fy;
  logic [3:0]        gy;
  logic [3:0]        row_sel;
  logic [8:0]        sw;
  logic [8:0]        sh;
  logic signed [10:0] y_base;
  logic signed [10:0] sy;
  logic signed [10:0] x_base;
  logic signed [10:0] col_x [SPRITE_SIZE];
  logic [SPRITE_SIZE-1:0] mask;
  logic              visible;

  assign code = {in_item.attr_b[4], in_item.attr_b[7:5], in_item.attr_a[5:0]};
  assign fx   = cfg.flip_x ^ in_item.attr_a[6];
  assign fy   = cfg.flip_y ^ in_item.attr_a[7];
  assign gy   = fy ? ~in_item.row : in_item.row;
  assign sw   = (cfg.screen_width  > 9'd256) ? 9'd256 : cfg.screen_width;
  assign sh   = (cfg.screen_height > 9'd256) ? 9'd256 : cfg.screen_height;

  // One wrap unit serves both the load address and the draw tile code
  assign code_sel = (in_item.mode == MODE_LOAD) ? in_item.load_address[13:4] : code;
  assign row_sel  = (in_item.mode == MODE_LOAD) ? in_item.load_address[3:0]  : gy;
  assign tile     = tile_wrap(code_sel);

  always_comb begin
    y_base = cfg.flip_y ? ($signed({3'b000, in_item.pos_y_byte}) - 11'sd8)
                        : (11'sd232 - $signed({3'b000, in_item.pos_y_byte}));
    sy     = y_base + $signed({7'b0000000, in_item.row});
    x_base = cfg.flip_x ? (11'sd240 - $signed({3'b000, in_item.pos_x_byte}))
                        : $signed({3'b000, in_item.pos_x_byte});
    for (int c = 0; c < SPRITE_SIZE; c++) begin
      col_x[c] = x_base + $signed(11'(c));
      mask[c]  = (col_x[c] >= 11'sd16) &&
                 ((col_x[c] + 11'sd16) < $signed({2'b00, sw}));
    end
    visible = (in_item.pos_y_byte != 8'd0) && (in_item.pos_x_byte != 8'd0) &&
              (sy >= 11'sd0) && (sy < $signed({2'b00, sh}));
  end

  assign in_stall = q_full;
  // Drop disabled and vertically clipped sprites here
  assign push     = in_valid && !q_full && ((in_item.mode == MODE_LOAD) || visible);

  always_comb begin
    cmd.is_load = (in_item.mode == MODE_LOAD);
    cmd.addr    = ADDR_FIELD_W'({tile, row_sel});
    cmd.pixels  = in_item.load_pixels;
    cmd.x       = x_base[7:0];
    cmd.y       = sy[7:0];
    cmd.mask    = mask;
    cmd.colour  = in_item.attr_b[2:0];
    cmd.fx      = fx;
  end

endmodule

// ----- src/srr_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on srr_pkg.
module srr_queue
  import srr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  srr_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output srr_cmd_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  srr_cmd_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1) else $error("push lost");

endmodule

// ----- src/srr_back.sv -----
`timescale 1ns / 1ps
// Back end: owns the tile store, executes loads and emits pixel writes for draws.
// Depends on srr_pkg and srr_ram.
module srr_back
  import srr_pkg::*;
#(
  parameter int TILE_COUNT = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  srr_cmd_t head,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output srr_out_t out_item
);

  localparam int ROWS = TILE_COUNT * SPRITE_SIZE;
  localparam int AW   = $clog2(ROWS);

  logic [ROW_W-1:0]       rd_data;
  logic                   e_busy;
  logic                   e_fresh;
  srr_cmd_t               e_cmd;
  logic [SPRITE_SIZE-1:0] live_reg;
  logic [SPRITE_SIZE-1:0] nz;
  logic [SPRITE_SIZE-1:0] cur_live;
  logic [SPRITE_SIZE-1:0] lowbit;
  logic [SPRITE_SIZE-1:0] rest;
  logic [2:0]             col_pix [SPRITE_SIZE];
  logic [3:0]             gc      [SPRITE_SIZE];
  logic [3:0]             col;
  logic                   out_free;
  logic                   emit;
  logic                   e_done;
  logic                   draw_pop;

  srr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_tile_store (
    .clk     (clk),
    .wr_en   (pop && head.is_load),
    .wr_addr (head.addr[AW-1:0]),
    .wr_data (head.pixels),
    .rd_en   (draw_pop),
    .rd_addr (head.addr[AW-1:0]),
    .rd_data (rd_data)
  );

  // Pick pixels in screen-column order; read data holds while a draw is active
  always_comb begin
    col = '0;
    for (int c = 0; c < SPRITE_SIZE; c++) begin
      gc[c]      = e_cmd.fx ? 4'(SPRITE_SIZE - 1 - c) : 4'(c);
      col_pix[c] = rd_data[PIXEL_W*gc[c] +: PIXEL_W];
      nz[c]      = (col_pix[c] != '0);
    end
    cur_live = e_fresh ? (e_cmd.mask & nz) : live_reg;
    lowbit   = cur_live & (~cur_live + 1'b1);
    rest     = cur_live & ~lowbit;
    for (int c = 0; c < SPRITE_SIZE; c++) begin
      if (lowbit[c]) begin
        col = 4'(c);
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign emit     = e_busy && (cur_live != '0) && out_free;
  assign e_done   = e_busy && ((cur_live == '0) || (emit && (rest == '0)));
  assign pop      = head_valid && (head.is_load || !e_busy || e_done);
  assign draw_pop = pop && !head.is_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_busy    <= 1'b0;
      e_fresh   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      e_fresh <= draw_pop;
      if (draw_pop) begin
        e_busy <= 1'b1;
      end else if (e_done) begin
        e_busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    live_reg <= emit ? rest : cur_live;
    if (draw_pop) begin
      e_cmd <= head;
    end
    if (emit) begin
      out_item.pixel_x     <= e_cmd.x + {4'b0000, col};
      out_item.pixel_y     <= e_cmd.y;
      out_item.pixel_value <= {e_cmd.colour, col_pix[col]};
      out_item.last        <= (rest == '0);
    end
  end

  a_pen_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.pixel_value[2:0] != 3'd0) else $error("transparent pixel sent");
  a_draw_starts: assert property (@(posedge clk) disable iff (rst)
    draw_pop |=> e_busy && e_fresh) else $error("draw did not start");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    e_done && !draw_pop |=> !e_busy) else $error("draw did not finish");
  a_fresh_busy: assert property (@(posedge clk) disable iff (rst)
    e_fresh |-> e_busy) else $error("fresh flag without active draw");

endmodule

// ----- src/sprite_row_renderer.sv -----
`timescale 1ns / 1ps
// Top level of the sprite row renderer: configuration registers, front end,
// command queue and back end. Depends on srr_pkg, srr_front, srr_queue, srr_back.
//
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+-------------------------
//  cfg     | cfg_write, cfg_index, cfg_data   | in        | one register write
//  in      | in_valid, in_stall, in_item      | in        | one load row or draw row
//  out     | out_valid, out_stall, out_item   | out       | one pixel write
//
// A load item writes the tile store as soon as it heads the queue, even during
// a draw. A draw item holds the back end until its last pixel (at most 16) is
// sent; its read is issued as the previous draw ends, so draws run back to back.
// Disabled and vertically clipped sprites are dropped in the front end.
// rst is synchronous: it clears the control state and restores the registers;
// the tile store is not cleared and is undefined until rows are loaded.
// in_stall rises only when the four-entry command queue is full; out_stall
// holds the output register and the back end waits behind it.
module sprite_row_renderer
  import srr_pkg::*;
#(
  parameter int TILE_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  srr_in_t                in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output srr_out_t               out_item
);

  srr_cfg_t cfg;
  srr_cmd_t push_cmd;
  srr_cmd_t head;
  logic     push;
  logic     q_full;
  logic     head_valid;
  logic     pop;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flip_x        <= 1'b0;
      cfg.flip_y        <= 1'b0;
      cfg.screen_width  <= 9'd240;
      cfg.screen_height <= 9'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FLIP_X:        cfg.flip_x        <= cfg_data[0];
        REG_FLIP_Y:        cfg.flip_y        <= cfg_data[0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode, clip and wrap addresses; push commands that still have work
  srr_front #(
    .TILE_COUNT (TILE_COUNT)
  ) u_front (
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Hold commands so the input side keeps flowing while pixels drain
  srr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Execute loads and draws in order against the tile store
  srr_back #(
    .TILE_COUNT (TILE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
